@@ rtl/ffr_pkg.sv @@
// ---------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants of the frame flip and rotate core.
// ---------------------------------------------------------------------------
`default_nettype none

package ffr_pkg;

    // request word, one per handshake on the req channel
    typedef struct packed {
        logic       operation;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } req_word_t;

    // response word, one per read request
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
        logic       not_ready;
    } rsp_word_t;

    typedef struct packed {
        logic [8:0] frame_width;
        logic [8:0] frame_height;
        logic [2:0] transform_mode;
    } cfg_t;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_TRANSFORM_MODE = 2'd2;

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_FLIP_H = 3'd1;
    localparam logic [2:0] MODE_FLIP_V = 3'd2;
    localparam logic [2:0] MODE_ROT90  = 3'd3;
    localparam logic [2:0] MODE_ROT180 = 3'd4;
    localparam logic [2:0] MODE_ROT270 = 3'd5;

    localparam logic [8:0] FRAME_WIDTH_RESET  = 9'd256;
    localparam logic [8:0] FRAME_HEIGHT_RESET = 9'd256;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_WR,
        ST_READ,
        ST_SYNC_PREP,
        ST_SYNC_DIV,
        ST_SYNC_END
    } ffr_state_t;

    typedef struct packed {
        logic load_accept;
        logic read_accept;
        logic mul_step;
        logic write_step;
        logic read_finish;
        logic div_start;
        logic div_step;
        logic div_commit;
    } ffr_cmd_t;

    typedef struct packed {
        logic frame_full;
        logic div_last;
        logic slot_free;
    } ffr_status_t;

endpackage

`default_nettype wire

@@ rtl/ffr_regs.sv @@
// ---------------------------------------------------------------------------
// ffr_regs
// APB-style configuration registers: frame width, height and transform mode.
// ---------------------------------------------------------------------------
`default_nettype none

module ffr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffr_pkg::ADDR_W-1:0]  paddr,
    input  logic [ffr_pkg::DATA_W-1:0]  pwdata,
    output logic [ffr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ffr_pkg::cfg_t               cfg,
    output logic                        cfg_changed
);
    import ffr_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index   = paddr[3:2];
    assign wr_en       = psel && penable && pwrite;
    assign pready      = 1'b1;
    assign cfg         = cfg_reg;
    assign cfg_changed = wr_en && (reg_index inside
                         {REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_TRANSFORM_MODE});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width    <= FRAME_WIDTH_RESET;
            cfg_reg.frame_height   <= FRAME_HEIGHT_RESET;
            cfg_reg.transform_mode <= MODE_NONE;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_FRAME_WIDTH:    cfg_reg.frame_width    <= pwdata[8:0];
                REG_FRAME_HEIGHT:   cfg_reg.frame_height   <= pwdata[8:0];
                REG_TRANSFORM_MODE: cfg_reg.transform_mode <= pwdata[2:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FRAME_WIDTH:    prdata = {{(DATA_W-9){1'b0}}, cfg_reg.frame_width};
            REG_FRAME_HEIGHT:   prdata = {{(DATA_W-9){1'b0}}, cfg_reg.frame_height};
            REG_TRANSFORM_MODE: prdata = {{(DATA_W-3){1'b0}}, cfg_reg.transform_mode};
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ffr_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffr_ctrl
// Sequencer: accepts words, steps the load and read paths, and runs the
// column/row realignment after reset and after each register write.
// ---------------------------------------------------------------------------
`default_nettype none

module ffr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_op,
    input  logic                 cfg_changed,
    input  ffr_pkg::ffr_status_t status,
    output logic                 req_stall,
    output ffr_pkg::ffr_cmd_t    cmd
);
    import ffr_pkg::*;

    ffr_state_t state_reg, state_next;
    logic       pending_reg, pending_next;
    logic       recent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b1;
            recent_reg  <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            recent_reg  <= cfg_changed;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (pending_reg)
                begin
                    state_next = ST_SYNC_PREP;
                end
                else
                begin
                    // a read needs the response register free
                    req_stall = (req_op == OP_READ) && !status.slot_free;
                    if (req_valid && !req_stall)
                    begin
                        if (req_op == OP_LOAD)
                        begin
                            cmd.load_accept = 1'b1;
                            state_next      = ST_LOAD_MUL;
                        end
                        else
                        begin
                            cmd.read_accept = 1'b1;
                            if (status.frame_full)
                            begin
                                state_next = ST_READ;
                            end
                        end
                    end
                end
            end
            ST_LOAD_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_LOAD_WR;
            end
            ST_LOAD_WR:
            begin
                cmd.write_step = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_READ:
            begin
                cmd.read_finish = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_SYNC_PREP:
            begin
                // wait while recent_reg shows a write, so the registered pixel total is current
                if (!recent_reg)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SYNC_DIV;
                end
            end
            ST_SYNC_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_SYNC_END;
                end
            end
            ST_SYNC_END:
            begin
                cmd.div_commit = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        pending_next = cfg_changed || (pending_reg && !cmd.div_start);
    end

endmodule

`default_nettype wire

@@ rtl/ffr_dpath.sv @@
// ---------------------------------------------------------------------------
// ffr_dpath
// Datapath: frame store, load and read counters, destination address unit,
// restoring divider for column/row realignment, response register.
// ---------------------------------------------------------------------------
`default_nettype none

module ffr_dpath #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffr_pkg::cfg_t        cfg,
    input  ffr_pkg::ffr_cmd_t    cmd,
    input  ffr_pkg::req_word_t   req,
    input  logic                 rsp_stall,
    output ffr_pkg::ffr_status_t status,
    output logic                 rsp_valid,
    output ffr_pkg::rsp_word_t   rsp
);
    import ffr_pkg::*;

    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned WH    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned DW    = (WW > WH) ? WW : WH;
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned TW    = $clog2(DEPTH + 1);
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(TW + 1);

    // frame store
    logic [23:0]      mem [DEPTH];
    logic [23:0]      rdata_reg;

    logic [WW-1:0]    w_clamp;
    logic [WH-1:0]    h_clamp;
    logic [WW+WH-1:0] wh_prod;
    logic [TW-1:0]    total_reg;
    logic [TW-1:0]    total_m1;

    logic [TW-1:0]    load_cnt_reg;
    logic [TW-1:0]    read_cnt_reg;
    logic             full_reg;
    logic [WW-1:0]    x_reg;
    logic [WH-1:0]    y_reg;
    logic [TW-1:0]    load_i;
    logic [TW-1:0]    read_i;
    logic             read_last;
    logic             load_last;
    logic [WW-1:0]    wm1x;
    logic [WH-1:0]    hm1y;

    logic [DW-1:0]    a_next, b_next;
    logic [TW-1:0]    c_next;
    logic [DW-1:0]    a_reg, b_reg;
    logic [TW-1:0]    c_reg;
    logic [2*DW-1:0]  prod_reg;
    logic [23:0]      pix_reg;
    logic             wr_en_reg;
    logic [AW-1:0]    wr_addr;

    logic             last_reg;
    logic             rsp_valid_reg;
    rsp_word_t        rsp_reg;

    logic [TW-1:0]    dvd_reg;
    logic [WW-1:0]    rem_reg;
    logic [CW-1:0]    div_cnt_reg;
    logic [WW:0]      trial;
    logic             trial_ge;

    // geometry with out-of-range sizes pinned
    always_comb
    begin
        if (cfg.frame_width == 9'd0)
        begin
            w_clamp = WW'(1);
        end
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
        begin
            w_clamp = WW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = WW'(cfg.frame_width);
        end
        if (cfg.frame_height == 9'd0)
        begin
            h_clamp = WH'(1);
        end
        else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT))
        begin
            h_clamp = WH'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = WH'(cfg.frame_height);
        end
    end

    assign wh_prod  = (WW+WH)'(w_clamp) * (WW+WH)'(h_clamp);
    assign total_m1 = total_reg - TW'(1);

    // counts past the current total act as the last pixel
    assign load_i    = (load_cnt_reg >= total_reg) ? total_m1 : load_cnt_reg;
    assign read_i    = (read_cnt_reg >= total_reg) ? total_m1 : read_cnt_reg;
    assign load_last = (load_i == total_m1);
    assign read_last = (read_i == total_m1);
    assign wm1x      = w_clamp - WW'(1) - x_reg;
    assign hm1y      = h_clamp - WH'(1) - y_reg;

    // destination address as a * b + c
    always_comb
    begin
        a_next = '0;
        b_next = '0;
        c_next = load_i;
        case (cfg.transform_mode)
            MODE_NONE:
            begin
                c_next = load_i;
            end
            MODE_FLIP_H:
            begin
                a_next = DW'(y_reg);
                b_next = DW'(w_clamp);
                c_next = TW'(wm1x);
            end
            MODE_FLIP_V:
            begin
                a_next = DW'(hm1y);
                b_next = DW'(w_clamp);
                c_next = TW'(x_reg);
            end
            MODE_ROT90:
            begin
                a_next = DW'(x_reg);
                b_next = DW'(h_clamp);
                c_next = TW'(hm1y);
            end
            MODE_ROT180:
            begin
                c_next = total_m1 - load_i;
            end
            MODE_ROT270:
            begin
                a_next = DW'(wm1x);
                b_next = DW'(h_clamp);
                c_next = TW'(y_reg);
            end
            default:
            begin
                c_next = load_i;
            end
        endcase
    end

    assign wr_addr  = AW'(prod_reg) + AW'(c_reg);
    assign trial    = {rem_reg, dvd_reg[TW-1]};
    assign trial_ge = (trial >= {1'b0, w_clamp});

    // unreset payload and pipeline registers
    always_ff @(posedge clk)
    begin
        total_reg <= TW'(wh_prod);
        if (cmd.load_accept && !full_reg)
        begin
            pix_reg <= {req.pixel_red, req.pixel_green, req.pixel_blue};
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= (2*DW)'(a_reg) * (2*DW)'(b_reg);
        end
        if (cmd.div_start)
        begin
            dvd_reg <= load_i;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? WW'(trial - {1'b0, w_clamp}) : WW'(trial);
            dvd_reg <= {dvd_reg[TW-2:0], trial_ge};
        end
        if (cmd.read_accept && full_reg)
        begin
            last_reg <= read_last;
        end
        if (cmd.read_accept && !full_reg)
        begin
            rsp_reg.out_red   <= 8'd0;
            rsp_reg.out_green <= 8'd0;
            rsp_reg.out_blue  <= 8'd0;
            rsp_reg.frame_end <= 1'b0;
            rsp_reg.not_ready <= 1'b1;
        end
        else if (cmd.read_finish)
        begin
            rsp_reg.out_red   <= rdata_reg[23:16];
            rsp_reg.out_green <= rdata_reg[15:8];
            rsp_reg.out_blue  <= rdata_reg[7:0];
            rsp_reg.frame_end <= last_reg;
            rsp_reg.not_ready <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_step && wr_en_reg)
        begin
            mem[wr_addr] <= pix_reg;
        end
        if (cmd.read_accept && full_reg)
        begin
            rdata_reg <= mem[AW'(read_i)];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg  <= '0;
            read_cnt_reg  <= '0;
            full_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            wr_en_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_accept)
            begin
                // a load into a full frame is dropped
                wr_en_reg <= !full_reg;
                if (!full_reg)
                begin
                    load_cnt_reg <= load_i + TW'(1);
                    full_reg     <= load_last;
                    if (x_reg + WW'(1) == w_clamp)
                    begin
                        x_reg <= '0;
                        y_reg <= y_reg + WH'(1);
                    end
                    else
                    begin
                        x_reg <= x_reg + WW'(1);
                    end
                end
            end
            if (cmd.read_accept && full_reg)
            begin
                if (read_last)
                begin
                    full_reg     <= 1'b0;
                    load_cnt_reg <= '0;
                    read_cnt_reg <= '0;
                    x_reg        <= '0;
                    y_reg        <= '0;
                end
                else
                begin
                    read_cnt_reg <= read_i + TW'(1);
                end
            end
            if (cmd.div_start)
            begin
                div_cnt_reg <= CW'(TW);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - CW'(1);
            end
            if (cmd.div_commit)
            begin
                x_reg <= rem_reg;
                y_reg <= WH'(dvd_reg);
            end
            // a new word may replace one taken at the same edge
            if ((cmd.read_accept && !full_reg) || cmd.read_finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign status.frame_full = full_reg;
    assign status.div_last   = (div_cnt_reg == CW'(1));
    assign status.slot_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid         = rsp_valid_reg;
    assign rsp               = rsp_reg;

endmodule

`default_nettype wire

@@ rtl/frame_flip_rotate_core.sv @@
// ---------------------------------------------------------------------------
// frame_flip_rotate_core
// Frame transformer for RGB pixels: flip or rotate one frame through a
// frame store, loaded in input raster order and read in output raster order.
// ---------------------------------------------------------------------------
//  channel  dir  handshake                    word
//  req      in   req_valid / req_stall        operation, pixel_red/green/blue
//  rsp      out  rsp_valid / rsp_stall        out_red/green/blue, frame_end,
//                                             not_ready
//  cfg      in   psel, penable, pwrite, pready (tied high)
//
//  a load word passes operand select, multiply and store write
//  a read word goes through the store read port, a not ready one does not
//  after reset and after each register write the req side stalls while the
//  divider realigns the load column and row; the store is not cleared
//  a response waiting in the output register holds back reads only
// ---------------------------------------------------------------------------
`default_nettype none

module frame_flip_rotate_core #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  ffr_pkg::req_word_t          req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output ffr_pkg::rsp_word_t          rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffr_pkg::ADDR_W-1:0]  paddr,
    input  logic [ffr_pkg::DATA_W-1:0]  pwdata,
    output logic [ffr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import ffr_pkg::*;

    cfg_t        cfg;
    logic        cfg_changed;
    ffr_cmd_t    cmd;
    ffr_status_t status;

    ffr_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .cfg_changed (cfg_changed)
    );

    ffr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_op      (req.operation),
        .cfg_changed (cfg_changed),
        .status      (status),
        .req_stall   (req_stall),
        .cmd         (cmd)
    );

    ffr_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .req       (req),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/ffr_checker.sv @@
// ---------------------------------------------------------------------------
// ffr_checker
// Port-level checks of the frame flip and rotate core, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module ffr_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  ffr_pkg::req_word_t          req,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  ffr_pkg::rsp_word_t          rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffr_pkg::ADDR_W-1:0]  paddr,
    input  logic                        pready
);
    import ffr_pkg::*;

    // a held response keeps its word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // a not ready response carries no pixel and no frame end
    a_not_ready_blank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.not_ready |->
            rsp.out_red == 8'd0 && rsp.out_green == 8'd0 &&
            rsp.out_blue == 8'd0 && !rsp.frame_end)
        else $error("not ready response with pixel data");

    // a register write stops new words while geometry realigns
    a_cfg_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready &&
        (paddr[3:2] == REG_FRAME_WIDTH || paddr[3:2] == REG_FRAME_HEIGHT ||
         paddr[3:2] == REG_TRANSFORM_MODE) |=> req_stall)
        else $error("word accepted right after a register write");

    // a load word stalls the req side in the next cycle, while it multiplies
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.operation == OP_LOAD |=> req_stall)
        else $error("word accepted during a load");

endmodule

bind frame_flip_rotate_core ffr_checker u_ffr_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_flip_rotate_core. Frames of pixels are loaded
// and read back over the req and rsp channels under many sizes and transform
// modes, with registers set over the APB port, and every response word is
// compared with a fixed word or with an in-bench model of the frame store.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

    import ffr_pkg::*;

    localparam int unsigned MAX_W       = 256;
    localparam int unsigned MAX_H       = 256;
    localparam int unsigned RAND_WORDS  = 1800;
    localparam int unsigned STALL_PCT   = 36;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned QUIET_FROM  = 700;
    localparam int unsigned QUIET_TO    = 1000;
    localparam int unsigned WATCHDOG    = 5000;
    localparam int unsigned MAX_REPORTS = 10;

    // mode codes with no transform of their own
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam rsp_word_t EARLY_WORD = '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
    localparam rsp_word_t WHITE_LAST = '{8'hff, 8'hff, 8'hff, 1'b1, 1'b0};
    localparam rsp_word_t NO_WORD    = '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    req_word_t         req;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_word_t         rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    frame_flip_rotate_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // frame store model and its registers
    logic [23:0] pixel_store [0:MAX_W*MAX_H-1];
    logic [16:0] loaded_count;
    logic [16:0] readout_count;
    logic        store_full;
    logic [8:0]  cfg_width;
    logic [8:0]  cfg_height;
    logic [2:0]  cfg_mode;
    int unsigned filled_span;   // entries below this index hold a loaded pixel
    bit          frame_clean;   // registers untouched since this frame began
    rsp_word_t   expected_pixels [$];

    int unsigned err_count   = 0;
    int unsigned n_loads     = 0;
    int unsigned n_reads     = 0;
    int unsigned n_early     = 0;
    int unsigned frames_done = 0;
    int unsigned cfg_writes  = 0;
    int unsigned items_sent  = 0;
    int unsigned rsp_count   = 0;
    int unsigned stuck_cycles = 0;
    bit          no_idle     = 1'b0;
    bit          hold_start  = 1'b0;
    bit          hold_done   = 1'b0;

    typedef struct packed {
        bit         is_reg;
        logic [1:0] sel;
        logic [8:0] val;
        req_word_t  word;
        bit         typed;
        rsp_word_t  rsp;
    } dir_row_t;

    dir_row_t dir_plan [$];

    function automatic void plan_reg(input logic [1:0] sel, input logic [8:0] val);
        dir_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.sel = sel;
        row.val = val;
        dir_plan = {dir_plan, row};
    endfunction

    function automatic void plan_word(input logic op, input logic [23:0] pix,
                                      input bit typed, input rsp_word_t r);
        dir_row_t row;
        row = '0;
        row.word = {op, pix};
        row.typed = typed;
        row.rsp = r;
        dir_plan = {dir_plan, row};
    endfunction

    function automatic int unsigned clamp_dim(input logic [8:0] v, input int unsigned lim);
        if (v == 9'd0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic int unsigned dest_index(input int unsigned i, input int unsigned fw,
                                               input int unsigned fh, input logic [2:0] mode);
        int unsigned x;
        int unsigned y;
        x = i % fw;
        y = i / fw;
        case (mode)
            MODE_FLIP_H: return y * fw + (fw - 1 - x);
            MODE_FLIP_V: return (fh - 1 - y) * fw + x;
            MODE_ROT90:  return x * fh + (fh - 1 - y);
            MODE_ROT180: return fw * fh - 1 - i;
            MODE_ROT270: return (fw - 1 - x) * fh + y;
            default:     return i;
        endcase
    endfunction

    task automatic transform_predict(input req_word_t w, output bit has_pixel,
                                     output bit dropped, output rsp_word_t r);
        int unsigned fw;
        int unsigned fh;
        int unsigned total;
        int unsigned idx;
        logic [23:0] pix;
        fw = clamp_dim(cfg_width, MAX_W);
        fh = clamp_dim(cfg_height, MAX_H);
        total = fw * fh;
        r = '0;
        has_pixel = 1'b0;
        dropped = 1'b0;
        if (w.operation == OP_LOAD)
        begin
            if (store_full)
                dropped = 1'b1;
            else
            begin
                idx = (loaded_count >= total) ? total - 1 : loaded_count;
                pixel_store[dest_index(idx, fw, fh, cfg_mode)] =
                    {w.pixel_red, w.pixel_green, w.pixel_blue};
                loaded_count = 17'(idx + 1);
                if (idx + 1 >= total)
                begin
                    store_full = 1'b1;
                    if (frame_clean && total > filled_span)
                        filled_span = total;
                end
            end
        end
        else
        begin
            has_pixel = 1'b1;
            if (!store_full)
                r.not_ready = 1'b1;
            else
            begin
                idx = (readout_count >= total) ? total - 1 : readout_count;
                pix = pixel_store[idx];
                {r.out_red, r.out_green, r.out_blue} = pix;
                r.frame_end = (idx + 1 >= total);
                if (r.frame_end)
                begin
                    store_full = 1'b0;
                    loaded_count = '0;
                    readout_count = '0;
                    frame_clean = 1'b1;
                end
                else
                    readout_count = 17'(idx + 1);
            end
        end
    endtask

    task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t typed_rsp);
        bit        has_pixel;
        bit        dropped;
        rsp_word_t r;
        while (!no_idle && $urandom_range(99) < STALL_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (req_stall);
        transform_predict(w, has_pixel, dropped, r);
        if (has_pixel)
            expected_pixels = {expected_pixels, (typed ? typed_rsp : r)};
        if (!dropped)
        begin
            items_sent++;
            if (w.operation == OP_LOAD)
                n_loads++;
            else
            begin
                n_reads++;
                if (r.not_ready)
                    n_early++;
                if (r.frame_end)
                    frames_done++;
            end
        end
    endtask

    task automatic apb_xfer(input logic wr, input logic [1:0] sel, input logic [8:0] val,
                            output logic [DATA_W-1:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {sel, 2'b00};
        pwdata <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [1:0] sel, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] rd;
        apb_xfer(1'b0, sel, 9'd0, rd);
        if (rd !== want)
        begin
            if (err_count < MAX_REPORTS)
                $display("register %0d readback: expected %h, got %h", sel, want, rd);
            err_count++;
        end
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [8:0] val);
        logic [DATA_W-1:0] rd;
        req_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        // a load may still be in the pipeline with nothing left to wait for
        repeat (6) @(posedge clk);
        apb_xfer(1'b1, sel, val, rd);
        if (loaded_count != 0 || store_full)
            frame_clean = 1'b0;
        case (sel)
            REG_FRAME_WIDTH:  cfg_width = val;
            REG_FRAME_HEIGHT: cfg_height = val;
            default:          cfg_mode = val[2:0];
        endcase
        cfg_writes++;
        check_reg(sel, (sel == REG_TRANSFORM_MODE) ? DATA_W'(val[2:0]) : DATA_W'(val));
    endtask

    task automatic write_frame_setup(input logic [8:0] fw, input logic [8:0] fh,
                                     input logic [2:0] mode);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_TRANSFORM_MODE, 9'(mode));
    endtask

    task automatic check_pixel(input rsp_word_t got);
        rsp_word_t want;
        rsp_count++;
        if (expected_pixels.size() == 0)
        begin
            if (err_count < MAX_REPORTS)
                $display("response word %h arrived with nothing expected", got);
            err_count++;
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                got.out_blue !== want.out_blue || got.frame_end !== want.frame_end ||
                got.not_ready !== want.not_ready)
            begin
                if (err_count < MAX_REPORTS)
                    $display("word %0d: expected %h, got %h (rgb, end, not ready)",
                             rsp_count, want, got);
                err_count++;
            end
        end
    endtask

    // response side: checks each accepted word, stalls at random, holds off once
    initial
    begin : rsp_side
        int unsigned hold_left;
        hold_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                check_pixel(rsp);
            if (hold_start && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (no_idle)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(99) < STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            stuck_cycles <= 0;
        else if (stuck_cycles + 1 >= WATCHDOG)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG);
            $display("TEST FAILED");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin : stimulus
        req_word_t   w;
        logic        op;
        logic [8:0]  fw;
        logic [8:0]  fh;
        int unsigned base_items;
        int unsigned base_frames;
        int          rnd_frame;
        int          cfg_frame;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_width = FRAME_WIDTH_RESET;
        cfg_height = FRAME_HEIGHT_RESET;
        cfg_mode = MODE_NONE;
        loaded_count = '0;
        readout_count = '0;
        store_full = 1'b0;
        filled_span = 0;
        frame_clean = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        check_reg(REG_FRAME_WIDTH, DATA_W'(FRAME_WIDTH_RESET));
        check_reg(REG_FRAME_HEIGHT, DATA_W'(FRAME_HEIGHT_RESET));
        check_reg(REG_TRANSFORM_MODE, DATA_W'(MODE_NONE));

        // nothing loaded yet
        plan_word(OP_READ, 24'h000000, 1'b1, EARLY_WORD);
        // zero sizes behave as a single pixel, spare mode as no transform
        plan_reg(REG_FRAME_WIDTH, 9'd0);
        plan_reg(REG_FRAME_HEIGHT, 9'd0);
        plan_reg(REG_TRANSFORM_MODE, 9'(MODE_SPARE_HI));
        plan_word(OP_LOAD, 24'hffffff, 1'b0, NO_WORD);
        plan_word(OP_LOAD, 24'h000000, 1'b0, NO_WORD);  // frame already full
        plan_word(OP_READ, 24'h000000, 1'b1, WHITE_LAST);
        plan_word(OP_READ, 24'hffffff, 1'b1, EARLY_WORD);
        plan_reg(REG_FRAME_WIDTH, 9'd2);
        plan_reg(REG_FRAME_HEIGHT, 9'd3);
        plan_reg(REG_TRANSFORM_MODE, 9'(MODE_ROT90));
        for (int i = 0; i < 6; i++)
        begin
            plan_word(OP_LOAD, {8'(8'h11 * i), 8'(8'hf0 - 8'h21 * i), 8'(8'h0f + 8'h30 * i)},
                      1'b0, NO_WORD);
            if (i == 2)
                plan_word(OP_READ, 24'h000000, 1'b1, EARLY_WORD);
        end
        for (int i = 0; i < 6; i++)
            plan_word(OP_READ, 24'h000000, 1'b0, NO_WORD);
        // load part of a frame, then shrink the frame while partly loaded
        plan_reg(REG_FRAME_WIDTH, 9'd3);
        plan_reg(REG_FRAME_HEIGHT, 9'd2);
        plan_reg(REG_TRANSFORM_MODE, 9'(MODE_FLIP_V));
        plan_word(OP_LOAD, 24'h123456, 1'b0, NO_WORD);
        plan_word(OP_LOAD, 24'h00ff00, 1'b0, NO_WORD);
        plan_reg(REG_FRAME_WIDTH, 9'd2);
        plan_reg(REG_FRAME_HEIGHT, 9'd2);
        plan_reg(REG_TRANSFORM_MODE, 9'(MODE_SPARE_LO));
        plan_word(OP_LOAD, 24'hff00ff, 1'b0, NO_WORD);
        plan_word(OP_LOAD, 24'h0000ff, 1'b0, NO_WORD);
        plan_word(OP_LOAD, 24'h777777, 1'b0, NO_WORD);
        for (int i = 0; i < 4; i++)
            plan_word(OP_READ, 24'h000000, 1'b0, NO_WORD);

        foreach (dir_plan[i])
        begin
            if (dir_plan[i].is_reg)
                write_reg(dir_plan[i].sel, dir_plan[i].val);
            else
                send_word(dir_plan[i].word, dir_plan[i].typed, dir_plan[i].rsp);
        end

        base_items = items_sent;
        base_frames = frames_done;
        cfg_frame = -1;
        while (items_sent - base_items < RAND_WORDS || loaded_count != 0 || store_full)
        begin
            rnd_frame = frames_done - base_frames;
            no_idle = (items_sent - base_items >= QUIET_FROM) &&
                      (items_sent - base_items < QUIET_TO);
            if (!store_full && loaded_count == 0 && rnd_frame != cfg_frame)
            begin
                cfg_frame = rnd_frame;
                // one full-width frame and one full-height frame, the rest small or left as they were
                if (rnd_frame == 0)
                    write_frame_setup(9'd256, 9'd1, 3'($urandom_range(7)));
                else if (rnd_frame == 6)
                    write_frame_setup(9'd1, 9'd511, 3'($urandom_range(7)));
                else if ($urandom_range(1) == 1)
                begin
                    fw = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(12, 1));
                    fh = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(12, 1));
                    write_frame_setup(fw, fh, 3'($urandom_range(7)));
                end
            end
            else if (filled_span >= 64 && (loaded_count != 0 || store_full) &&
                     $urandom_range(59) == 0)
            begin
                // mid-frame change, kept inside the part of the store already filled
                write_frame_setup(9'($urandom_range(8, 1)), 9'($urandom_range(8, 1)),
                                  3'($urandom_range(7)));
            end
            if (store_full)
                op = ($urandom_range(99) < 92) ? OP_READ : OP_LOAD;
            else
                op = ($urandom_range(99) < 94) ? OP_LOAD : OP_READ;
            w.operation = op;
            {w.pixel_red, w.pixel_green, w.pixel_blue} = 24'($urandom());
            send_word(w, 1'b0, NO_WORD);
            if (rnd_frame == 0 && store_full)
                hold_start = 1'b1;
        end
        no_idle = 1'b0;

        req_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        err_count += expected_pixels.size();

        $display("ran %0d loads and %0d reads (%0d before the frame was complete), %0d frames",
                 n_loads, n_reads, n_early, frames_done);
        $display("%0d register writes, %0d response words checked, %0d mismatches",
                 cfg_writes, rsp_count, err_count);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
